>>> rtl/rfd_pkg.sv
// Shared constants, types and helper functions for the remote frame decoder.
package rfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int KEY_COUNT   = 16;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int KEY_W       = $clog2(KEY_COUNT);
    localparam int CNT_W       = 16;
    localparam int GROUPS      = 3;
    localparam int ROW_W       = GROUPS * CNT_W;
    localparam int CH_W        = 11;
    localparam int VAL_W       = 12;
    localparam int SHIFT_BIT   = 4;
    localparam int CTRL_BIT    = 5;
    localparam int CFG_W       = 11;

    localparam logic [CFG_W-1:0] OFFSET_RESET = CFG_W'(1024);
    localparam logic [CFG_W-1:0] LIMIT_RESET  = CFG_W'(660);

    localparam logic [KEY_COUNT-1:0] COUNT_MASK =
        ~((KEY_COUNT'(1) << SHIFT_BIT) | (KEY_COUNT'(1) << CTRL_BIT));

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        GRP_PLAIN = 2'd0,
        GRP_CTRL  = 2'd1,
        GRP_SHIFT = 2'd2,
        GRP_NONE  = 2'd3
    } grp_t;

    typedef enum logic {
        KIND_FRAME = 1'b0,
        KIND_COUNT = 1'b1
    } kind_t;

    typedef enum logic {
        REG_OFFSET = 1'b0,
        REG_LIMIT  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] right_x;
        logic signed [VAL_W-1:0] right_y;
        logic signed [VAL_W-1:0] left_x;
        logic signed [VAL_W-1:0] left_y;
        logic signed [VAL_W-1:0] dial_value;
        logic [3:0]              switch_bits;
        logic signed [15:0]      mouse_dx;
        logic signed [15:0]      mouse_dy;
        logic [1:0]              mouse_buttons;
        logic [15:0]             key_bits;
    } frame_fields_t;

    typedef struct packed {
        logic             clear;
        logic             frame_done;
        logic             rd_en;
        grp_t             rd_group;
        logic [KEY_W-1:0] rd_index;
    } cnt_ctl_t;

    function automatic logic signed [VAL_W-1:0] shape_channel(
        input logic [CH_W-1:0]  raw,
        input logic [CFG_W-1:0] offset,
        input logic [CFG_W-1:0] limit
    );
        logic signed [VAL_W-1:0] diff;
        logic [VAL_W-1:0]        mag;
        diff = $signed({1'b0, raw}) - $signed({1'b0, offset});
        mag  = diff[VAL_W-1] ? $unsigned(-diff) : $unsigned(diff);
        if (mag > {1'b0, limit})
            return '0;
        return diff;
    endfunction

endpackage

>>> rtl/rfd_frame_asm.sv
// Frame byte assembly, byte position tracking and field decode.
module rfd_frame_asm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic                        clear,
    input  logic                        frame_start,
    input  logic [7:0]                  frame_byte,
    input  logic [rfd_pkg::CFG_W-1:0]   channel_offset,
    input  logic [rfd_pkg::CFG_W-1:0]   stick_limit,
    output logic                        is_last,
    output logic [rfd_pkg::KEY_COUNT-1:0] keys,
    output rfd_pkg::frame_fields_t      fields
);
    import rfd_pkg::*;

    logic [7:0]       frame_reg [FRAME_BYTES];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] eff_pos;

    always_comb
    begin
        if (frame_start || ({1'b0, pos_reg} >= (POS_W+1)'(FRAME_BYTES)))
            eff_pos = '0;
        else
            eff_pos = pos_reg;
    end

    assign is_last = (eff_pos == POS_W'(FRAME_BYTES - 1));

    always_comb
    begin
        pos_next = pos_reg;
        if (clear)
            pos_next = '0;
        else if (wr_en)
            pos_next = is_last ? '0 : POS_W'(eff_pos + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (wr_en && eff_pos == POS_W'(i))
                frame_reg[i] <= frame_byte;
        end
    end

    assign keys = {frame_reg[15], frame_reg[14]};

    always_comb
    begin
        fields.right_x = shape_channel({frame_reg[1][2:0], frame_reg[0]},
                                       channel_offset, stick_limit);
        fields.right_y = shape_channel({frame_reg[2][5:0], frame_reg[1][7:3]},
                                       channel_offset, stick_limit);
        fields.left_x  = shape_channel({frame_reg[4][0], frame_reg[3], frame_reg[2][7:6]},
                                       channel_offset, stick_limit);
        fields.left_y  = shape_channel({frame_reg[5][3:0], frame_reg[4][7:1]},
                                       channel_offset, stick_limit);
        fields.dial_value = shape_channel({frame_reg[17][2:0], frame_reg[16]},
                                          channel_offset, stick_limit);
        fields.switch_bits   = frame_reg[5][7:4];
        fields.mouse_dx      = $signed({frame_reg[7], frame_reg[6]});
        fields.mouse_dy      = $signed({frame_reg[9], frame_reg[8]});
        fields.mouse_buttons = {(frame_reg[13] != 8'd0), (frame_reg[12] != 8'd0)};
        fields.key_bits      = {frame_reg[15], frame_reg[14]};
    end

endmodule

>>> rtl/rfd_key_counters.sv
// Key press edge detection and press counter memory with row sweep update.
module rfd_key_counters (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rfd_pkg::cnt_ctl_t             ctl,
    input  logic [rfd_pkg::KEY_COUNT-1:0] keys,
    output logic                          busy,
    output logic [rfd_pkg::CNT_W-1:0]     count_value
);
    import rfd_pkg::*;

    logic [ROW_W-1:0]     mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] row_valid_reg;

    logic [KEY_COUNT-1:0] prev_reg;
    logic [KEY_COUNT-1:0] prev_ctrl_reg;
    logic [KEY_COUNT-1:0] prev_shift_reg;
    logic [KEY_COUNT-1:0] inc_reg [GROUPS];

    logic [KEY_COUNT-1:0] with_ctrl;
    logic [KEY_COUNT-1:0] with_shift;

    logic             sweep_rd_reg;
    logic [KEY_W-1:0] sweep_idx_reg;
    logic             wr_pend_reg;
    logic [KEY_W-1:0] wr_idx_reg;

    logic             rd_fire;
    logic [KEY_W-1:0] rd_addr;
    logic [ROW_W-1:0] rdata_reg;
    logic             rvalid_reg;
    grp_t             rd_group_reg;
    logic [ROW_W-1:0] wdata;
    logic [ROW_W-1:0] old_row;

    assign with_ctrl  = keys[CTRL_BIT]  ? keys : '0;
    assign with_shift = keys[SHIFT_BIT] ? keys : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            prev_ctrl_reg  <= '0;
            prev_shift_reg <= '0;
        end
        else if (ctl.clear)
        begin
            prev_reg       <= '0;
            prev_ctrl_reg  <= '0;
            prev_shift_reg <= '0;
        end
        else if (ctl.frame_done)
        begin
            prev_reg       <= keys;
            prev_ctrl_reg  <= with_ctrl;
            prev_shift_reg <= with_shift;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.frame_done)
        begin
            inc_reg[GRP_PLAIN] <= keys & ~prev_reg & ~with_ctrl & ~with_shift & COUNT_MASK;
            inc_reg[GRP_CTRL]  <= with_ctrl & ~prev_ctrl_reg & COUNT_MASK;
            inc_reg[GRP_SHIFT] <= with_shift & ~prev_shift_reg & COUNT_MASK;
        end
    end

    // sweep: read row i while row i-1 is written back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_rd_reg  <= 1'b0;
            sweep_idx_reg <= '0;
            wr_pend_reg   <= 1'b0;
            wr_idx_reg    <= '0;
        end
        else
        begin
            wr_pend_reg <= sweep_rd_reg;
            wr_idx_reg  <= sweep_idx_reg;
            if (ctl.frame_done)
            begin
                sweep_rd_reg  <= 1'b1;
                sweep_idx_reg <= '0;
            end
            else if (sweep_rd_reg)
            begin
                if (sweep_idx_reg == KEY_W'(KEY_COUNT - 1))
                    sweep_rd_reg <= 1'b0;
                sweep_idx_reg <= KEY_W'(sweep_idx_reg + 1'b1);
            end
        end
    end

    assign busy    = sweep_rd_reg || wr_pend_reg;
    assign rd_fire = sweep_rd_reg || ctl.rd_en;
    assign rd_addr = sweep_rd_reg ? sweep_idx_reg : ctl.rd_index;

    assign old_row = rvalid_reg ? rdata_reg : '0;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
            wdata[g*CNT_W +: CNT_W] = old_row[g*CNT_W +: CNT_W]
                                    + CNT_W'(inc_reg[g][wr_idx_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
            mem[wr_idx_reg] <= wdata;
        if (rd_fire)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
            rd_group_reg  <= GRP_NONE;
        end
        else
        begin
            if (ctl.clear)
                row_valid_reg <= '0;
            else if (wr_pend_reg)
                row_valid_reg[wr_idx_reg] <= 1'b1;
            if (rd_fire)
                rvalid_reg <= row_valid_reg[rd_addr];
            if (ctl.rd_en)
                rd_group_reg <= ctl.rd_group;
        end
    end

    always_comb
    begin
        unique case (rd_group_reg)
            GRP_PLAIN: count_value = old_row[0*CNT_W +: CNT_W];
            GRP_CTRL:  count_value = old_row[1*CNT_W +: CNT_W];
            GRP_SHIFT: count_value = old_row[2*CNT_W +: CNT_W];
            default:   count_value = '0;
        endcase
    end

endmodule

>>> rtl/remote_frame_decoder_key_counter_unit.sv
// Remote frame decoder top level: handshakes, config registers, result staging.
// Result path: a result from an accepted transaction (last frame byte or counter
// read) passes a staging register, then the output register, and is offered from there.
// Throughput: one input transaction per cycle while the result staging has room; after
// the last byte of a frame the press counter memory is swept row by row, during which counter reads,
// clears and the next last byte are held off (other frame bytes keep flowing).
// Reset: asynchronous, active low; counters read as zero and config returns to defaults.
module remote_frame_decoder_key_counter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rfd_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [7:0]                        frame_byte,
    input  logic                              frame_start,
    input  logic [1:0]                        count_group,
    input  logic [3:0]                        key_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              result_kind,
    output logic signed [11:0]                right_x,
    output logic signed [11:0]                right_y,
    output logic signed [11:0]                left_x,
    output logic signed [11:0]                left_y,
    output logic signed [11:0]                dial_value,
    output logic [3:0]                        switch_bits,
    output logic signed [15:0]                mouse_dx,
    output logic signed [15:0]                mouse_dy,
    output logic [1:0]                        mouse_buttons,
    output logic [15:0]                       key_bits,
    output logic [15:0]                       key_press_count
);
    import rfd_pkg::*;

    logic [CFG_W-1:0] offset_reg;
    logic [CFG_W-1:0] limit_reg;

    cmd_t          cmd_in;
    logic          accept;
    logic          is_last;
    logic          busy;
    logic          can_adv;
    logic          slot_free;
    logic          hold;
    logic          makes_result;
    logic          s1_valid_reg;
    kind_t         s1_kind_reg;
    logic          out_valid_reg;
    kind_t         out_kind_reg;
    frame_fields_t out_fields_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic [KEY_COUNT-1:0] keys;
    frame_fields_t        dec_fields;
    logic [CNT_W-1:0]     count_value;
    cnt_ctl_t             ctl;

    assign cmd_in = cmd_t'(cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_OFFSET: offset_reg <= cfg_wdata;
                REG_LIMIT:  limit_reg  <= cfg_wdata;
            endcase
        end
    end

    assign can_adv   = !out_valid_reg || out_ready;
    assign slot_free = !s1_valid_reg || can_adv;
    assign hold      = busy && ((cmd_in == CMD_READ) || (cmd_in == CMD_CLEAR)
                                || ((cmd_in == CMD_BYTE) && is_last));
    assign in_ready  = slot_free && !hold;
    assign accept    = in_valid && in_ready;
    assign makes_result = (cmd_in == CMD_READ) || ((cmd_in == CMD_BYTE) && is_last);

    always_comb
    begin
        ctl.clear      = accept && (cmd_in == CMD_CLEAR);
        ctl.frame_done = accept && (cmd_in == CMD_BYTE) && is_last;
        ctl.rd_en      = accept && (cmd_in == CMD_READ);
        ctl.rd_group   = grp_t'(count_group);
        ctl.rd_index   = key_index;
    end

    rfd_frame_asm u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (accept && (cmd_in == CMD_BYTE)),
        .clear          (ctl.clear),
        .frame_start    (frame_start),
        .frame_byte     (frame_byte),
        .channel_offset (offset_reg),
        .stick_limit    (limit_reg),
        .is_last        (is_last),
        .keys           (keys),
        .fields         (dec_fields)
    );

    rfd_key_counters u_counters (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .keys        (keys),
        .busy        (busy),
        .count_value (count_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_kind_reg   <= KIND_FRAME;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && makes_result)
            begin
                s1_valid_reg <= 1'b1;
                s1_kind_reg  <= (cmd_in == CMD_READ) ? KIND_COUNT : KIND_FRAME;
            end
            else if (can_adv)
                s1_valid_reg <= 1'b0;

            if (s1_valid_reg && can_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && can_adv)
        begin
            out_kind_reg <= s1_kind_reg;
            unique case (s1_kind_reg)
                KIND_FRAME:
                begin
                    out_fields_reg <= dec_fields;
                    out_count_reg  <= '0;
                end
                KIND_COUNT:
                begin
                    out_fields_reg <= '0;
                    out_count_reg  <= count_value;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_kind_reg;
    assign right_x         = out_fields_reg.right_x;
    assign right_y         = out_fields_reg.right_y;
    assign left_x          = out_fields_reg.left_x;
    assign left_y          = out_fields_reg.left_y;
    assign dial_value      = out_fields_reg.dial_value;
    assign switch_bits     = out_fields_reg.switch_bits;
    assign mouse_dx        = out_fields_reg.mouse_dx;
    assign mouse_dy        = out_fields_reg.mouse_dy;
    assign mouse_buttons   = out_fields_reg.mouse_buttons;
    assign key_bits        = out_fields_reg.key_bits;
    assign key_press_count = out_count_reg;

endmodule

>>> tb/remote_frame_decoder_key_counter_unit_test.sv
// Self-checking testbench for the remote frame decoder with key press counters.
`timescale 1ns / 1ps

module remote_frame_decoder_key_counter_unit_test;
    import rfd_pkg::*;

    localparam int FRAME_BITS   = FRAME_BYTES * 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 95;

    typedef struct packed {
        cmd_t        op;
        logic [7:0]  data;
        logic        start;
        grp_t        group;
        logic [3:0]  key;
    } remote_item_t;

    typedef struct packed {
        kind_t          kind;
        frame_fields_t  f;
        logic [15:0]    count;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = 2'd0;
    logic [7:0] frame_byte = 8'd0;
    logic frame_start = 1'b0;
    logic [1:0] count_group = 2'd0;
    logic [3:0] key_index = 4'd0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic result_kind;
    logic signed [11:0] right_x, right_y, left_x, left_y, dial_value;
    logic [3:0] switch_bits;
    logic signed [15:0] mouse_dx, mouse_dy;
    logic [1:0] mouse_buttons;
    logic [15:0] key_bits, key_press_count;

    remote_frame_decoder_key_counter_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .frame_byte(frame_byte), .frame_start(frame_start),
        .count_group(count_group), .key_index(key_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind),
        .right_x(right_x), .right_y(right_y), .left_x(left_x), .left_y(left_y),
        .dial_value(dial_value), .switch_bits(switch_bits),
        .mouse_dx(mouse_dx), .mouse_dy(mouse_dy), .mouse_buttons(mouse_buttons),
        .key_bits(key_bits), .key_press_count(key_press_count)
    );

    // decoder copy kept by the testbench
    logic [CFG_W-1:0] offset_cfg = OFFSET_RESET;
    logic [CFG_W-1:0] limit_cfg = LIMIT_RESET;
    logic [7:0] frame_mem [FRAME_BYTES];
    int frame_pos;
    logic [15:0] prev_keys, prev_ctrl, prev_shift;
    logic [15:0] press_count [GROUPS][KEY_COUNT];

    remote_item_t item_q[$];
    decoded_t due_q[$];
    remote_item_t cur_item;

    bit quiet = 1'b0;
    int send_gap = 0;
    int take_gap = 0;
    int errors = 0;
    int stim_count = 0;
    int sent_count = 0;
    int frames_seen = 0;
    int reads_seen = 0;
    int clears_seen = 0;
    int results_seen = 0;
    int settings_used = 0;
    int cycle_count = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_model();
        frame_pos = 0;
        prev_keys = '0;
        prev_ctrl = '0;
        prev_shift = '0;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_mem[i] = '0;
        for (int g = 0; g < GROUPS; g++)
            for (int k = 0; k < KEY_COUNT; k++)
                press_count[g][k] = '0;
    endfunction

    function automatic logic signed [11:0] centered(input logic [CH_W-1:0] raw);
        int v;
        int mag;
        v = int'(raw) - int'(offset_cfg);
        mag = (v < 0) ? -v : v;
        if (mag > int'(limit_cfg))
            v = 0;
        return v[11:0];
    endfunction

    function automatic void advance_decoder(input remote_item_t it);
        decoded_t r;
        logic [FRAME_BITS-1:0] bits;
        logic [15:0] keys, with_ctrl, with_shift;
        r = '0;
        sent_count++;
        case (it.op)
            CMD_BYTE: begin
                if (it.start)
                    frame_pos = 0;
                frame_mem[frame_pos] = it.data;
                if (frame_pos == FRAME_BYTES - 1) begin
                    frame_pos = 0;
                    for (int i = 0; i < FRAME_BYTES; i++)
                        bits[8*i +: 8] = frame_mem[i];
                    keys = bits[127:112];
                    with_ctrl = keys[CTRL_BIT] ? keys : 16'd0;
                    with_shift = keys[SHIFT_BIT] ? keys : 16'd0;
                    for (int i = 0; i < KEY_COUNT; i++) begin
                        if (i != SHIFT_BIT && i != CTRL_BIT) begin
                            if (keys[i] && !prev_keys[i] && !with_ctrl[i] && !with_shift[i])
                                press_count[GRP_PLAIN][i] = press_count[GRP_PLAIN][i] + 16'd1;
                            if (with_ctrl[i] && !prev_ctrl[i])
                                press_count[GRP_CTRL][i] = press_count[GRP_CTRL][i] + 16'd1;
                            if (with_shift[i] && !prev_shift[i])
                                press_count[GRP_SHIFT][i] = press_count[GRP_SHIFT][i] + 16'd1;
                        end
                    end
                    prev_keys = keys;
                    prev_ctrl = with_ctrl;
                    prev_shift = with_shift;
                    r.kind = KIND_FRAME;
                    r.f.right_x = centered(bits[10:0]);
                    r.f.right_y = centered(bits[21:11]);
                    r.f.left_x = centered(bits[32:22]);
                    r.f.left_y = centered(bits[43:33]);
                    r.f.dial_value = centered(bits[138:128]);
                    r.f.switch_bits = bits[47:44];
                    r.f.mouse_dx = bits[63:48];
                    r.f.mouse_dy = bits[79:64];
                    r.f.mouse_buttons = {bits[111:104] != 8'd0, bits[103:96] != 8'd0};
                    r.f.key_bits = keys;
                    due_q.push_back(r);
                    frames_seen++;
                end else begin
                    frame_pos++;
                end
            end
            CMD_READ: begin
                r.kind = KIND_COUNT;
                if (it.group != GRP_NONE)
                    r.count = press_count[int'(it.group)][it.key];
                due_q.push_back(r);
                reads_seen++;
            end
            CMD_CLEAR: begin
                clear_model();
                clears_seen++;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      results_seen, name, got, want));
    endtask

    // driver
    always @(posedge clk) begin
        logic accepted;
        if (rst_n) begin
            accepted = in_valid && in_ready;
            if (accepted) begin
                advance_decoder(cur_item);
                send_gap = quiet ? 0 : $urandom_range(0, 15);
            end
            if (!in_valid || accepted) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    cur_item = item_q.pop_front();
                    in_valid <= 1'b1;
                    cmd <= cur_item.op;
                    frame_byte <= cur_item.data;
                    frame_start <= cur_item.start;
                    count_group <= cur_item.group;
                    key_index <= cur_item.key;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        decoded_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (due_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing due",
                                              results_seen));
                end else begin
                    want = due_q.pop_front();
                    check_field("result_kind", 16'(result_kind), 16'(want.kind));
                    check_field("right_x", 16'(right_x), 16'(want.f.right_x));
                    check_field("right_y", 16'(right_y), 16'(want.f.right_y));
                    check_field("left_x", 16'(left_x), 16'(want.f.left_x));
                    check_field("left_y", 16'(left_y), 16'(want.f.left_y));
                    check_field("dial_value", 16'(dial_value), 16'(want.f.dial_value));
                    check_field("switch_bits", 16'(switch_bits), 16'(want.f.switch_bits));
                    check_field("mouse_dx", mouse_dx, want.f.mouse_dx);
                    check_field("mouse_dy", mouse_dy, want.f.mouse_dy);
                    check_field("mouse_buttons", 16'(mouse_buttons),
                                16'(want.f.mouse_buttons));
                    check_field("key_bits", key_bits, want.f.key_bits);
                    check_field("key_press_count", key_press_count, want.count);
                end
                take_gap = quiet ? 0 : $urandom_range(0, 15);
            end else if (take_gap > 0) begin
                take_gap--;
            end
            out_ready <= (take_gap == 0);
        end
    end

    task automatic add_byte(input logic [7:0] data, input logic start);
        remote_item_t it;
        it.op = CMD_BYTE;
        it.data = data;
        it.start = start;
        it.group = grp_t'(2'($urandom_range(0, 3)));
        it.key = 4'($urandom);
        item_q.push_back(it);
        stim_count++;
    endtask

    task automatic add_cmd(input cmd_t op, input grp_t group, input logic [3:0] key);
        remote_item_t it;
        it.op = op;
        it.data = 8'($urandom);
        it.start = 1'($urandom);
        it.group = group;
        it.key = key;
        item_q.push_back(it);
        if (op != CMD_NONE)
            stim_count++;
    endtask

    // half the picks near the centre so that the limit boundary is hit
    function automatic logic [CH_W-1:0] pick_channel();
        int v;
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            v = 0;
        else if (pick == 1)
            v = 2047;
        else if (pick < 4)
            v = $urandom_range(0, 2047);
        else
            v = int'(offset_cfg) + int'($urandom_range(0, 2 * int'(limit_cfg) + 2))
                - int'(limit_cfg) - 1;
        if (v < 0)
            v = 0;
        if (v > 2047)
            v = 2047;
        return v[CH_W-1:0];
    endfunction

    task automatic add_frame(input int len, input logic with_start);
        logic [FRAME_BITS-1:0] bits;
        logic [15:0] keys;
        for (int i = 0; i < FRAME_BYTES; i++)
            bits[8*i +: 8] = 8'($urandom);
        bits[10:0] = pick_channel();
        bits[21:11] = pick_channel();
        bits[32:22] = pick_channel();
        bits[43:33] = pick_channel();
        bits[138:128] = pick_channel();
        if ($urandom_range(0, 1) == 0)
            bits[103:96] = 8'd0;
        if ($urandom_range(0, 1) == 0)
            bits[111:104] = 8'd0;
        keys = 16'($urandom & $urandom & $urandom);
        keys[SHIFT_BIT] = ($urandom_range(0, 2) == 0);
        keys[CTRL_BIT] = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) == 0)
            keys = 16'($urandom);
        bits[127:112] = keys;
        for (int i = 0; i < len; i++)
            add_byte(bits[8*i +: 8], (i == 0) ? with_start : 1'b0);
    endtask

    task automatic fill_phase(input int target);
        int first;
        int pick;
        first = stim_count;
        while (stim_count - first < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                add_frame(FRAME_BYTES, 1'b1);
            end else if (pick < 15) begin
                repeat ($urandom_range(1, 4))
                    add_cmd(CMD_READ, grp_t'(2'($urandom_range(0, 3))), 4'($urandom));
            end else if (pick == 15) begin
                add_frame($urandom_range(1, FRAME_BYTES - 1), 1'b1);
            end else if (pick == 16) begin
                add_frame(FRAME_BYTES, 1'b0);
            end else if (pick == 17) begin
                add_cmd(CMD_CLEAR, grp_t'(2'($urandom_range(0, 3))), 4'($urandom));
            end else if (pick == 18) begin
                add_cmd(CMD_NONE, grp_t'(2'($urandom_range(0, 3))), 4'($urandom));
            end else begin
                add_byte(8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_OFFSET)
            offset_cfg = value;
        else
            limit_cfg = value;
    endtask

    // sender holds off until every transaction is in and every result is out
    task automatic wait_idle();
        while (!(item_q.size() == 0 && !in_valid && due_q.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 due_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] offsets [PHASES];
        logic [CFG_W-1:0] limits [PHASES];
        offsets = '{11'd1024, 11'd0, 11'd2047, 11'd1024, 11'd0, 11'd2047,
                    11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047))};
        limits = '{11'd660, 11'd1024, 11'd1024, 11'd0, 11'd0, 11'd660,
                   11'($urandom_range(0, 1024)), 11'($urandom_range(0, 1024))};
        clear_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            write_reg(REG_OFFSET, offsets[ph]);
            write_reg(REG_LIMIT, limits[ph]);
            settings_used++;
            quiet = (ph % 3 == 2);
            if (ph == 0) begin
                // all-ones frame: every key with shift and ctrl held, negative mouse
                for (int i = 0; i < FRAME_BYTES; i++)
                    add_byte(8'hFF, i == 0);
                add_cmd(CMD_READ, GRP_CTRL, 4'd0);
                add_cmd(CMD_READ, GRP_SHIFT, 4'd15);
                add_cmd(CMD_READ, GRP_PLAIN, 4'(SHIFT_BIT));
                add_cmd(CMD_READ, GRP_NONE, 4'd3);
                add_cmd(CMD_CLEAR, GRP_PLAIN, 4'd0);
                add_cmd(CMD_NONE, GRP_SHIFT, 4'd9);
                add_cmd(CMD_READ, GRP_CTRL, 4'd0);
            end else begin
                fill_phase(PHASE_ITEMS);
            end
        end
        wait_idle();
        $display("Sent %0d transactions under %0d register settings: %0d frames decoded,",
                 sent_count, settings_used, frames_seen);
        $display("%0d counter reads, %0d clears, %0d results checked, %0d cycles.",
                 reads_seen, clears_seen, results_seen, cycle_count);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
